// ----- sv/ipv4p_pkg.sv -----
// Package with the types, codes and constants of the IPv4 address text parser.
package ipv4p_pkg;

    // Parse phase of the current part.
    typedef enum logic [2:0] {
        PH_START  = 3'd0,
        PH_ZERO   = 3'd1,
        PH_DIGITS = 3'd2,
        PH_TRAIL  = 3'd3,
        PH_FAIL   = 3'd4
    } t_phase;

    // Number base of the current part.
    typedef enum logic [1:0] {
        RX_DEC = 2'd0,
        RX_OCT = 2'd1,
        RX_HEX = 2'd2
    } t_radix;

    // Character codes that the parser recognizes.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_X_LO  = 8'h78;
    localparam logic [7:0] CH_X_UP  = 8'h58;
    localparam logic [7:0] CH_A_LO  = 8'h61;
    localparam logic [7:0] CH_F_LO  = 8'h66;
    localparam logic [7:0] CH_A_UP  = 8'h41;
    localparam logic [7:0] CH_F_UP  = 8'h46;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;

    // Range limits of the last part for two, three and four parts.
    localparam logic [31:0] MAX_24 = 32'h00ff_ffff;
    localparam logic [31:0] MAX_16 = 32'h0000_ffff;
    localparam logic [31:0] MAX_8  = 32'h0000_00ff;

    // Number of leading parts that are held as single bytes.
    localparam int unsigned NUM_PARTS = 3;

    // Per-string parser state.
    typedef struct packed {
        t_phase      phase;
        t_radix      radix;
        logic [31:0] accumulator;
        logic        overflowed;
        logic        digit_seen;
        logic [1:0]  part_count;
    } t_state;

    // One result item.
    typedef struct packed {
        logic        valid_res;
        logic [31:0] address;
    } t_result;

    // Leading part bytes.
    typedef logic [NUM_PARTS-1:0][7:0] t_parts;

    localparam t_state STATE_RESET = '{
        phase:       PH_START,
        radix:       RX_DEC,
        accumulator: 32'd0,
        overflowed:  1'b0,
        digit_seen:  1'b0,
        part_count:  2'd0
    };

endpackage

// ----- sv/ipv4p_step.sv -----
// Next-state and result logic of the IPv4 address text parser for one byte.
module ipv4p_step (
    input  logic [7:0]        i_byte,
    input  ipv4p_pkg::t_state i_state,
    input  ipv4p_pkg::t_parts i_parts,
    output ipv4p_pkg::t_state o_next,
    output logic              o_part_we,
    output logic [1:0]        o_part_idx,
    output logic              o_done,
    output ipv4p_pkg::t_result o_res
);

    // Multiply the accumulator by the radix and add a digit; bit 32 and up flag overflow.
    function automatic logic [35:0] mac(input logic [31:0] acc, input ipv4p_pkg::t_radix rx,
                                        input logic [3:0] d);
        logic [35:0] w;
        logic [35:0] p;
        w = {4'd0, acc};
        case (rx)
            ipv4p_pkg::RX_HEX: p = w << 4;
            ipv4p_pkg::RX_OCT: p = w << 3;
            default:           p = (w << 3) + (w << 1);
        endcase
        return p + {32'd0, d};
    endfunction

    logic              is_dig;
    logic              is_hexl;
    logic              is_space;
    logic [3:0]        dig_val;
    logic [3:0]        hex_val;
    logic [35:0]       sum_dig;
    logic [35:0]       sum_hex;
    ipv4p_pkg::t_state dn;
    logic              d_we;
    logic              fin_ok;
    logic              range_ok;
    logic [31:0]       fin_addr;

    // Byte classes.
    assign is_dig   = (i_byte >= ipv4p_pkg::CH_ZERO) && (i_byte <= ipv4p_pkg::CH_NINE);
    assign is_hexl  = ((i_byte >= ipv4p_pkg::CH_A_LO) && (i_byte <= ipv4p_pkg::CH_F_LO)) ||
                      ((i_byte >= ipv4p_pkg::CH_A_UP) && (i_byte <= ipv4p_pkg::CH_F_UP));
    assign is_space = (i_byte == ipv4p_pkg::CH_SPACE) || (i_byte == ipv4p_pkg::CH_TAB) ||
                      (i_byte == ipv4p_pkg::CH_LF) || (i_byte == ipv4p_pkg::CH_CR);
    assign dig_val  = i_byte[3:0];
    assign hex_val  = {1'b0, i_byte[2:0]} + 4'd9;
    assign sum_dig  = mac(i_state.accumulator, i_state.radix, dig_val);
    assign sum_hex  = mac(i_state.accumulator, ipv4p_pkg::RX_HEX, hex_val);

    // Handling of a byte inside the digits of a part.
    always_comb begin
        dn   = i_state;
        d_we = 1'b0;
        if (is_dig) begin
            if ((i_state.radix == ipv4p_pkg::RX_OCT) && dig_val[3]) begin
                dn.phase = ipv4p_pkg::PH_FAIL;
            end else begin
                dn.accumulator = sum_dig[31:0];
                dn.overflowed  = i_state.overflowed | (sum_dig[35:32] != 4'd0);
                dn.digit_seen  = 1'b1;
                dn.phase       = ipv4p_pkg::PH_DIGITS;
            end
        end else if ((i_state.radix == ipv4p_pkg::RX_HEX) && is_hexl) begin
            dn.accumulator = sum_hex[31:0];
            dn.overflowed  = i_state.overflowed | (sum_hex[35:32] != 4'd0);
            dn.digit_seen  = 1'b1;
            dn.phase       = ipv4p_pkg::PH_DIGITS;
        end else if (i_byte == ipv4p_pkg::CH_DOT) begin
            if ((i_state.part_count == 2'd3) || i_state.overflowed ||
                (i_state.accumulator > ipv4p_pkg::MAX_8)) begin
                dn.phase = ipv4p_pkg::PH_FAIL;
            end else begin
                d_we           = 1'b1;
                dn.part_count  = i_state.part_count + 2'd1;
                dn.accumulator = 32'd0;
                dn.radix       = ipv4p_pkg::RX_DEC;
                dn.digit_seen  = 1'b0;
                dn.phase       = ipv4p_pkg::PH_START;
            end
        end else if (is_space) begin
            dn.phase = ipv4p_pkg::PH_TRAIL;
        end else begin
            dn.phase = ipv4p_pkg::PH_FAIL;
        end
    end

    // Validity and assembly of the address at the terminator.
    always_comb begin
        case (i_state.part_count)
            2'd0: begin
                range_ok = 1'b1;
                fin_addr = i_state.accumulator;
            end
            2'd1: begin
                range_ok = i_state.accumulator <= ipv4p_pkg::MAX_24;
                fin_addr = {i_parts[0], i_state.accumulator[23:0]};
            end
            2'd2: begin
                range_ok = i_state.accumulator <= ipv4p_pkg::MAX_16;
                fin_addr = {i_parts[0], i_parts[1], i_state.accumulator[15:0]};
            end
            default: begin
                range_ok = i_state.accumulator <= ipv4p_pkg::MAX_8;
                fin_addr = {i_parts[0], i_parts[1], i_parts[2], i_state.accumulator[7:0]};
            end
        endcase
        fin_ok = (i_state.phase inside {ipv4p_pkg::PH_ZERO, ipv4p_pkg::PH_DIGITS,
                                        ipv4p_pkg::PH_TRAIL}) &&
                 i_state.digit_seen && !i_state.overflowed && range_ok;
    end

    // Phase sequencer for one byte.
    always_comb begin
        o_next     = i_state;
        o_part_we  = 1'b0;
        o_part_idx = i_state.part_count;
        o_done     = (i_byte == ipv4p_pkg::CH_NUL);
        o_res.valid_res = fin_ok;
        o_res.address   = fin_ok ? fin_addr : 32'd0;
        if (o_done) begin
            o_next = ipv4p_pkg::STATE_RESET;
        end else begin
            unique case (i_state.phase)
                ipv4p_pkg::PH_START: begin
                    if (!is_dig) begin
                        o_next.phase = ipv4p_pkg::PH_FAIL;
                    end else if (i_byte == ipv4p_pkg::CH_ZERO) begin
                        o_next.radix       = ipv4p_pkg::RX_OCT;
                        o_next.digit_seen  = 1'b1;
                        o_next.accumulator = 32'd0;
                        o_next.phase       = ipv4p_pkg::PH_ZERO;
                    end else begin
                        o_next.radix       = ipv4p_pkg::RX_DEC;
                        o_next.digit_seen  = 1'b1;
                        o_next.accumulator = {28'd0, dig_val};
                        o_next.phase       = ipv4p_pkg::PH_DIGITS;
                    end
                end
                ipv4p_pkg::PH_ZERO: begin
                    if ((i_byte == ipv4p_pkg::CH_X_LO) || (i_byte == ipv4p_pkg::CH_X_UP)) begin
                        o_next.radix      = ipv4p_pkg::RX_HEX;
                        o_next.digit_seen = 1'b0;
                        o_next.phase      = ipv4p_pkg::PH_DIGITS;
                    end else begin
                        o_next    = dn;
                        o_part_we = d_we;
                    end
                end
                ipv4p_pkg::PH_DIGITS: begin
                    o_next    = dn;
                    o_part_we = d_we;
                end
                ipv4p_pkg::PH_TRAIL: begin
                    o_next = i_state;
                end
                default: begin
                    o_next.phase = ipv4p_pkg::PH_FAIL;
                end
            endcase
        end
    end

endmodule

// ----- sv/ipv4_address_text_parser.sv -----
// Top level of the IPv4 address text parser: input register, parser state and result register.
// Throughput: one text byte per cycle, unless a terminator waits on a blocked result register.
// The parse step is a shift-add update; a zero byte passes the input register, then the result register.
// The result register parts the sides: bytes other than a terminator keep flowing while a result waits.
// Reset: synchronous, active low; clears parser state and both valid flags.
// The leading part bytes are not reset; each string writes them before it reads them.
module ipv4_address_text_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_text_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_valid_res,
    output logic [31:0] o_address
);

    logic               r_in_valid;
    logic [7:0]         r_in_byte;
    ipv4p_pkg::t_state  r_state;
    ipv4p_pkg::t_parts  r_parts;
    logic               r_out_valid;
    ipv4p_pkg::t_result r_res;

    ipv4p_pkg::t_state  n_state;
    ipv4p_pkg::t_result n_res;
    logic               part_we;
    logic [1:0]         part_idx;
    logic               done;
    logic               advance;

    ipv4p_step u_step (
        .i_byte     (r_in_byte),
        .i_state    (r_state),
        .i_parts    (r_parts),
        .o_next     (n_state),
        .o_part_we  (part_we),
        .o_part_idx (part_idx),
        .o_done     (done),
        .o_res      (n_res)
    );

    // A held byte moves on unless it is a terminator and the result register is blocked.
    assign advance = r_in_valid && (!done || !r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !advance;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
        if (i_valid && !o_stall) begin
            r_in_byte <= i_text_byte;
        end
    end

    // Parser state and leading part bytes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ipv4p_pkg::STATE_RESET;
        end else if (advance) begin
            r_state <= n_state;
        end
        if (advance && part_we) begin
            r_parts[part_idx] <= r_state.accumulator[7:0];
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && done) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
        if (advance && done) begin
            r_res <= n_res;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_valid_res = r_res.valid_res;
    assign o_address   = r_res.address;

`ifndef SYNTH
    // Reset leaves no result pending.
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result pending after reset");

    // An invalid result carries a zero address.
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_valid_res) |-> (o_address == 32'd0))
        else $error("invalid result with nonzero address");

    // A terminator that moves on yields a result and restarts the parser.
    a_term_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && done) |=> (r_out_valid && (r_state == ipv4p_pkg::STATE_RESET)))
        else $error("terminator did not produce a result");

    // A pending result that is stalled is never overwritten by a new terminator.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |-> !(advance && done))
        else $error("pending result overwritten");
`endif

endmodule

// ----- dv/ipv4_address_text_parser_checker.sv -----
`timescale 1ns / 1ps
// Checker that predicts the parsed address of each string and compares it with the block's results.
module ipv4_address_text_parser_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        o_stall,
    input  logic [7:0]  i_text_byte,
    input  logic        o_valid,
    input  logic        i_stall,
    input  logic        o_valid_res,
    input  logic [31:0] o_address,
    output int          o_fail_count,
    output int          o_pending
);

    // Parser state of the prediction.
    ipv4p_pkg::t_phase cur_phase;
    ipv4p_pkg::t_radix cur_radix;
    logic [31:0]       acc;
    logic              ovf;
    logic              saw_dig;
    logic [1:0]        nparts;
    ipv4p_pkg::t_parts lead_parts;

    // Addresses predicted for strings whose terminator has been transferred.
    ipv4p_pkg::t_result address_q[$];
    int                 fail_total = 0;

    assign o_fail_count = fail_total;

    // Prints one mismatch line and counts it.
    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("mismatch at %0t: %s: expected %h, got %h", $realtime, what, want, got);
        fail_total++;
    endtask

    // Returns the parser to the start of a new string.
    task automatic clear_parser();
        cur_phase  = ipv4p_pkg::PH_START;
        cur_radix  = ipv4p_pkg::RX_DEC;
        acc        = 32'd0;
        ovf        = 1'b0;
        saw_dig    = 1'b0;
        nparts     = 2'd0;
        lead_parts = '0;
    endtask

    function automatic logic is_blank(input logic [7:0] ch);
        return ch == ipv4p_pkg::CH_SPACE || ch == ipv4p_pkg::CH_TAB ||
               ch == ipv4p_pkg::CH_LF || ch == ipv4p_pkg::CH_CR;
    endfunction

    function automatic logic is_decimal(input logic [7:0] ch);
        return ch >= ipv4p_pkg::CH_ZERO && ch <= ipv4p_pkg::CH_NINE;
    endfunction

    // Value of a hex letter, or 16 when the byte is not one.
    function automatic logic [4:0] hex_value(input logic [7:0] ch);
        if (ch >= ipv4p_pkg::CH_A_LO && ch <= ipv4p_pkg::CH_F_LO) begin
            return 5'(ch - ipv4p_pkg::CH_A_LO) + 5'd10;
        end
        if (ch >= ipv4p_pkg::CH_A_UP && ch <= ipv4p_pkg::CH_F_UP) begin
            return 5'(ch - ipv4p_pkg::CH_A_UP) + 5'd10;
        end
        return 5'd16;
    endfunction

    // Shift-add of one digit, with the carry out of 32 bits kept as overflow.
    task automatic push_digit(input logic [4:0] mult, input logic [3:0] digit);
        logic [63:0] wide;
        wide = {32'd0, acc} * {59'd0, mult} + {60'd0, digit};
        if (wide[63:32] != 32'd0) ovf = 1'b1;
        acc     = wide[31:0];
        saw_dig = 1'b1;
    endtask

    // One byte inside the digits of a part, or right after a leading zero.
    task automatic digit_in_part(input logic [7:0] ch);
        logic [4:0] hv;
        logic [3:0] dv;
        hv = hex_value(ch);
        dv = 4'(ch - ipv4p_pkg::CH_ZERO);
        if (is_decimal(ch)) begin
            if (cur_radix == ipv4p_pkg::RX_OCT && dv >= 4'd8) begin
                cur_phase = ipv4p_pkg::PH_FAIL;
            end else begin
                push_digit(cur_radix == ipv4p_pkg::RX_HEX ? 5'd16 :
                           (cur_radix == ipv4p_pkg::RX_OCT ? 5'd8 : 5'd10), dv);
                cur_phase = ipv4p_pkg::PH_DIGITS;
            end
        end else if (cur_radix == ipv4p_pkg::RX_HEX && hv < 5'd16) begin
            push_digit(5'd16, hv[3:0]);
            cur_phase = ipv4p_pkg::PH_DIGITS;
        end else if (ch == ipv4p_pkg::CH_DOT) begin
            // A leading part must fit one byte, and at most three of them exist.
            if (nparts == 2'd3 || ovf || acc > ipv4p_pkg::MAX_8) begin
                cur_phase = ipv4p_pkg::PH_FAIL;
            end else begin
                lead_parts[nparts] = acc[7:0];
                nparts    = nparts + 2'd1;
                acc       = 32'd0;
                cur_radix = ipv4p_pkg::RX_DEC;
                saw_dig   = 1'b0;
                cur_phase = ipv4p_pkg::PH_START;
            end
        end else if (is_blank(ch)) begin
            cur_phase = ipv4p_pkg::PH_TRAIL;
        end else begin
            cur_phase = ipv4p_pkg::PH_FAIL;
        end
    endtask

    // Advances the parser by one nonzero text byte.
    task automatic step_parser(input logic [7:0] ch);
        case (cur_phase)
            ipv4p_pkg::PH_START: begin
                if (!is_decimal(ch)) begin
                    cur_phase = ipv4p_pkg::PH_FAIL;
                end else if (ch == ipv4p_pkg::CH_ZERO) begin
                    cur_radix = ipv4p_pkg::RX_OCT;
                    saw_dig   = 1'b1;
                    acc       = 32'd0;
                    cur_phase = ipv4p_pkg::PH_ZERO;
                end else begin
                    cur_radix = ipv4p_pkg::RX_DEC;
                    saw_dig   = 1'b0;
                    acc       = 32'd0;
                    push_digit(5'd10, 4'(ch - ipv4p_pkg::CH_ZERO));
                    cur_phase = ipv4p_pkg::PH_DIGITS;
                end
            end
            ipv4p_pkg::PH_ZERO: begin
                if (ch == ipv4p_pkg::CH_X_LO || ch == ipv4p_pkg::CH_X_UP) begin
                    cur_radix = ipv4p_pkg::RX_HEX;
                    saw_dig   = 1'b0;
                    cur_phase = ipv4p_pkg::PH_DIGITS;
                end else begin
                    digit_in_part(ch);
                end
            end
            ipv4p_pkg::PH_DIGITS: digit_in_part(ch);
            ipv4p_pkg::PH_TRAIL: ;
            default: cur_phase = ipv4p_pkg::PH_FAIL;
        endcase
    endtask

    // Address of the string at its terminator; the last part's range depends on the part count.
    function automatic ipv4p_pkg::t_result close_string();
        ipv4p_pkg::t_result res;
        logic [31:0]        v;
        res = '0;
        v   = acc;
        if (!(cur_phase == ipv4p_pkg::PH_ZERO || cur_phase == ipv4p_pkg::PH_DIGITS ||
              cur_phase == ipv4p_pkg::PH_TRAIL)) begin
            return res;
        end
        if (!saw_dig || ovf) return res;
        case (nparts)
            2'd0: ;
            2'd1: begin
                if (v > ipv4p_pkg::MAX_24) return res;
                v = v | {lead_parts[0], 24'd0};
            end
            2'd2: begin
                if (v > ipv4p_pkg::MAX_16) return res;
                v = v | {lead_parts[0], lead_parts[1], 16'd0};
            end
            default: begin
                if (v > ipv4p_pkg::MAX_8) return res;
                v = v | {lead_parts[0], lead_parts[1], lead_parts[2], 8'd0};
            end
        endcase
        res.valid_res = 1'b1;
        res.address   = v;
        return res;
    endfunction

    // Follows input transfers, checks output transfers against the oldest prediction.
    always @(posedge i_clk) begin
        ipv4p_pkg::t_result want;
        if (!i_rst_n) begin
            clear_parser();
            address_q.delete();
        end else begin
            if (i_valid && !o_stall) begin
                if (i_text_byte == ipv4p_pkg::CH_NUL) begin
                    address_q.push_back(close_string());
                    clear_parser();
                end else begin
                    step_parser(i_text_byte);
                end
            end
            if (o_valid && !i_stall) begin
                if (address_q.size() == 0) begin
                    report_mismatch("result with no string pending", 32'd0, o_address);
                end else begin
                    want = address_q.pop_front();
                    if (o_valid_res !== want.valid_res) begin
                        report_mismatch("valid_res", {31'd0, want.valid_res},
                                        {31'd0, o_valid_res});
                    end
                    if (o_address !== want.address) begin
                        report_mismatch("address", want.address, o_address);
                    end
                end
            end
        end
        o_pending <= address_q.size();
    end

endmodule

// ----- dv/ipv4_address_text_parser_test.sv -----
`timescale 1ns / 1ps
// Testbench top of the IPv4 address text parser: clock, reset, text stimulus and verdict.
module ipv4_address_text_parser_test;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int TEXT_BYTES   = 1750;
    localparam int DRAIN_CYCLES = 8;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic [7:0]  i_text_byte = 8'd0;
    logic        i_stall     = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic        o_valid_res;
    logic [31:0] o_address;

    int          fail_count;
    int          pending_count;
    int          cycle_count = 0;
    int          bytes_sent  = 0;
    int          stall_left  = 0;
    logic        send_gaps   = 1'b0;
    logic        stall_gaps  = 1'b0;

    // Bytes of the string being sent, terminator included.
    logic [7:0]  text_q[$];

    ipv4_address_text_parser u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_text_byte (i_text_byte),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_valid_res (o_valid_res),
        .o_address   (o_address)
    );

    ipv4_address_text_parser_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_text_byte  (i_text_byte),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_valid_res  (o_valid_res),
        .o_address    (o_address),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    always #1 i_clk = ~i_clk;

    // Guard against a hung handshake.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Result side stalls in random bursts while enabled.
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else if (stall_gaps && $urandom_range(0, 5) == 0) begin
            i_stall    <= 1'b1;
            stall_left <= $urandom_range(0, 13);
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Drives one byte, possibly after an idle burst, and waits for its transfer.
    task automatic send_byte(input logic [7:0] b);
        if (send_gaps && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_text_byte <= b;
        do @(posedge i_clk); while (o_stall);
        bytes_sent++;
    endtask

    task automatic send_text();
        while (text_q.size() > 0) send_byte(text_q.pop_front());
    endtask

    task automatic add_text(input string s);
        for (int k = 0; k < s.len(); k++) text_q.push_back(s.getc(k));
    endtask

    task automatic send_string(input string s);
        add_text(s);
        text_q.push_back(ipv4p_pkg::CH_NUL);
        send_text();
    endtask

    // Turns hex letters and the x of the prefix to upper case at random.
    function automatic string mixed_case(input string s);
        byte c;
        for (int k = 0; k < s.len(); k++) begin
            c = s.getc(k);
            if (((c >= ipv4p_pkg::CH_A_LO && c <= ipv4p_pkg::CH_F_LO) ||
                 c == ipv4p_pkg::CH_X_LO) && $urandom_range(0, 1)) begin
                s.putc(k, c - 8'h20);
            end
        end
        return s;
    endfunction

    // Part value within or around the range limit, sometimes past 32 bits.
    function automatic logic [63:0] pick_value(input logic [31:0] limit);
        logic [63:0] v;
        case ($urandom_range(0, 9))
            6: begin
                case ($urandom_range(0, 2))
                    0: v = 64'd0;
                    1: v = {32'd0, limit};
                    default: v = {32'd0, limit} + 64'd1;
                endcase
            end
            7: v = {32'd0, limit} + 64'd1 + 64'($urandom_range(0, 255));
            8: v = {$urandom, $urandom} >> $urandom_range(0, 40);
            9: v = 64'($urandom_range(0, 15));
            default: v = 64'($urandom_range(0, limit));
        endcase
        return v;
    endfunction

    // Writes one part in decimal, octal or hex; a bare hex prefix now and then.
    function automatic string format_part(input logic [63:0] v);
        string s;
        if ($urandom_range(0, 24) == 0) return mixed_case("0x");
        case ($urandom_range(0, 3))
            0, 1: s = $sformatf("%0d", v);
            2: begin
                if (v != 0 && $urandom_range(0, 3) == 0) begin
                    s = "00";
                end else begin
                    s = "0";
                end
                s = {s, $sformatf("%0o", v)};
            end
            default: begin
                if ($urandom_range(0, 3) == 0) begin
                    s = "0x00";
                end else begin
                    s = "0x";
                end
                s = mixed_case({s, $sformatf("%0h", v)});
            end
        endcase
        return s;
    endfunction

    // Builds a well-formed address string, then breaks or extends it now and then.
    task automatic add_address();
        int          part_total;
        logic [31:0] last_limit;
        logic [7:0]  blank;
        int          pos;
        part_total = $urandom_range(1, 4);
        for (int k = 0; k < part_total - 1; k++) begin
            add_text(format_part(pick_value(ipv4p_pkg::MAX_8)));
            add_text(".");
        end
        case (part_total)
            1: last_limit = 32'hffff_ffff;
            2: last_limit = ipv4p_pkg::MAX_24;
            3: last_limit = ipv4p_pkg::MAX_16;
            default: last_limit = ipv4p_pkg::MAX_8;
        endcase
        add_text(format_part(pick_value(last_limit)));
        case ($urandom_range(0, 7))
            // Whitespace end, with ignored bytes after it.
            0: begin
                case ($urandom_range(0, 3))
                    0: blank = ipv4p_pkg::CH_SPACE;
                    1: blank = ipv4p_pkg::CH_TAB;
                    2: blank = ipv4p_pkg::CH_LF;
                    default: blank = ipv4p_pkg::CH_CR;
                endcase
                text_q.push_back(blank);
                repeat ($urandom_range(0, 5)) text_q.push_back(8'($urandom_range(1, 255)));
            end
            // One byte replaced by an arbitrary one.
            1: begin
                pos = $urandom_range(0, text_q.size() - 1);
                text_q[pos] = 8'($urandom_range(1, 255));
            end
            // A further part, or a missing one after a trailing dot.
            2: begin
                add_text(".");
                if ($urandom_range(0, 1)) add_text(format_part(pick_value(ipv4p_pkg::MAX_8)));
            end
            default: ;
        endcase
        text_q.push_back(ipv4p_pkg::CH_NUL);
    endtask

    // Random bytes leaning on the characters the parser knows.
    task automatic add_noise();
        repeat ($urandom_range(0, 12)) begin
            case ($urandom_range(0, 4))
                0: text_q.push_back(ipv4p_pkg::CH_DOT);
                1: text_q.push_back(ipv4p_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
                2: text_q.push_back(($urandom_range(0, 1)) ? ipv4p_pkg::CH_X_LO :
                                                             ipv4p_pkg::CH_X_UP);
                3: text_q.push_back(ipv4p_pkg::CH_A_UP + 8'($urandom_range(0, 5)));
                default: text_q.push_back(8'($urandom_range(1, 255)));
            endcase
        end
        text_q.push_back(ipv4p_pkg::CH_NUL);
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed strings: empty, missing part, lone hex prefix last and leading,
        // bad octal digit, whitespace end, mixed-case hex, top byte value.
        send_string("");
        send_string("1.");
        send_string("0x");
        send_string("0x.1");
        send_string("08");
        send_string("1 z");
        send_string("0XaF");
        text_q.push_back(8'hff);
        send_string("");

        // Random strings, with idling switched on and off in stretches.
        send_gaps  = 1'b1;
        stall_gaps = 1'b1;
        while (bytes_sent < TEXT_BYTES) begin
            if ($urandom_range(0, 9) == 0) begin
                send_gaps  = 1'($urandom_range(0, 1));
                stall_gaps = 1'($urandom_range(0, 1));
            end
            if (bytes_sent > TEXT_BYTES * 4 / 5) begin
                send_gaps  = 1'b0;
                stall_gaps = 1'b0;
            end
            if ($urandom_range(0, 9) == 0) begin
                add_noise();
            end else begin
                add_address();
            end
            send_text();
        end
        i_valid <= 1'b0;

        // Drain the outstanding results, then give the verdict.
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
